### rtl/assert_macros.svh
// assertion macros shared by the onset detector rtl
// checks sample on clk and are off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge
`define RROD_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RROD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rrod_pkg.sv
// shared constants, types and helpers for the rms ratio onset detector
// no dependencies; imported by every rrod module
`timescale 1ns / 1ps
`default_nettype none

package rrod_pkg;

  localparam int MAX_WINDOW = 4096;
  localparam int HIST_AW    = $clog2(MAX_WINDOW);
  localparam int FILL_W     = HIST_AW + 1;
  localparam int IDX_W      = 24;
  localparam int SMP_W      = 16;
  localparam int SQ_W       = 2 * SMP_W - 1;
  localparam int ENG_W      = 42;
  localparam int RUN_W      = 48;
  localparam int CWIN_W     = 13;
  localparam int RATIO_W    = 16;
  localparam int Q_FRAC     = 8;
  localparam int PROD_W     = RATIO_W + ENG_W;
  localparam int CFG_W      = 42;
  localparam int CFG_AW     = 3;
  localparam int OUT_DATA_W = ((IDX_W + ENG_W + 7) / 8) * 8;

  localparam logic [IDX_W-1:0]   START_RESET = '0;
  localparam logic [IDX_W-1:0]   LIMIT_RESET = '1;
  localparam logic [CWIN_W-1:0]  WIN_RESET   = CWIN_W'(1024);
  localparam logic [CWIN_W-1:0]  HOP_RESET   = CWIN_W'(512);
  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(1024);
  localparam logic [ENG_W-1:0]   THR_RESET   = '0;
  localparam logic [RATIO_W-1:0] RATIO_ONE   = RATIO_W'(256);

  typedef enum logic [CFG_AW-1:0] {
    CFG_START_INDEX      = 3'd0,
    CFG_SEARCH_LIMIT     = 3'd1,
    CFG_WINDOW_SIZE      = 3'd2,
    CFG_HOP_LENGTH       = 3'd3,
    CFG_RATIO_Q8         = 3'd4,
    CFG_ENERGY_THRESHOLD = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0]   start_index;
    logic [IDX_W-1:0]   search_limit;
    logic [CWIN_W-1:0]  window_size;
    logic [CWIN_W-1:0]  hop_length;
    logic [RATIO_W-1:0] ratio_q8;
    logic [ENG_W-1:0]   energy_threshold;
  } cfg_t;

  // after the history stage
  typedef struct packed {
    logic                    valid;
    logic                    restart;
    logic                    old_valid;
    logic signed [SMP_W-1:0] sample;
    logic [IDX_W-1:0]        idx;
  } s1_t;

  // after the squaring stage
  typedef struct packed {
    logic             valid;
    logic             restart;
    logic [SQ_W-1:0]  sq;
    logic [SQ_W-1:0]  old_sq;
    logic [IDX_W-1:0] idx;
  } s2_t;

  // after the accumulate stage
  typedef struct packed {
    logic             valid;
    logic             restart;
    logic [IDX_W-1:0] idx;
  } s3_t;

  function automatic logic [CWIN_W-1:0] clamp_window(input logic [CWIN_W-1:0] ws);
    logic [CWIN_W-1:0] res;
    res = ws;
    if (ws == '0) res = CWIN_W'(1);
    else if (int'(ws) > MAX_WINDOW) res = CWIN_W'(MAX_WINDOW);
    return res;
  endfunction

  function automatic logic [CWIN_W-1:0] clamp_hop(input logic [CWIN_W-1:0] hl);
    logic [CWIN_W-1:0] res;
    res = (hl == '0) ? CWIN_W'(1) : hl;
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/rms_ratio_onset_detector_unit.sv
// top level of the rms ratio onset detector: config registers and pipeline
// depends on rrod_pkg, rrod_hist, rrod_energy, rrod_decide
//
//  channel | direction | handshake            | payload
//  in_     | slave     | in_tvalid/in_tready  | tdata: sample; tuser: action
//  out_    | master    | out_tvalid/out_tready| tdata: window_start, window_energy; tuser: found
//  cfg_    | write     | cfg_wr_en            | cfg_index, cfg_wdata
//
// one input item per cycle while not stalled; out_tvalid rises after the transfer that causes
// it, through four register stages (history ram read, squaring, running sum, decision)
// the running sum and window state each close a loop through a single register, which sets the rate
// a sample stalls in the decision stage only while a result is still held and a
// restart has reopened the search; samples after a result otherwise flow and are dropped
// rst_n is synchronous; the history ram is not cleared, a fill count masks stale slots
`timescale 1ns / 1ps
`default_nettype none

module rms_ratio_onset_detector_unit import rrod_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [SMP_W-1:0]      in_tdata,    // [15:0] sample
  input  wire logic [0:0]            in_tuser,    // [0] action
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,   // [23:0] window_start, [65:24] window_energy
  output logic [0:0]                 out_tuser,   // [0] found
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_AW-1:0]     cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_wdata
);

  cfg_t              cfg_r, cfg_nxt;
  logic              stall, en;
  logic [CWIN_W-1:0] win;
  s1_t               s1;
  logic [SMP_W-1:0]  s1_old_sample;
  s3_t               s3;
  logic [RUN_W-1:0]  run;
  logic              found;
  logic [IDX_W-1:0]  start;
  logic [ENG_W-1:0]  energy;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_START_INDEX:      cfg_nxt.start_index      = cfg_wdata[IDX_W-1:0];
        CFG_SEARCH_LIMIT:     cfg_nxt.search_limit     = cfg_wdata[IDX_W-1:0];
        CFG_WINDOW_SIZE:      cfg_nxt.window_size      = cfg_wdata[CWIN_W-1:0];
        CFG_HOP_LENGTH:       cfg_nxt.hop_length       = cfg_wdata[CWIN_W-1:0];
        CFG_RATIO_Q8:         cfg_nxt.ratio_q8         = cfg_wdata[RATIO_W-1:0];
        CFG_ENERGY_THRESHOLD: cfg_nxt.energy_threshold = cfg_wdata[ENG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_index      <= START_RESET;
      cfg_r.search_limit     <= LIMIT_RESET;
      cfg_r.window_size      <= WIN_RESET;
      cfg_r.hop_length       <= HOP_RESET;
      cfg_r.ratio_q8         <= RATIO_RESET;
      cfg_r.energy_threshold <= THR_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign en        = !stall;
  assign in_tready = en && rst_n;
  assign win       = clamp_window(cfg_r.window_size);

  rrod_hist u_hist (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_tvalid),
    .in_restart    (in_tuser[0]),
    .in_sample     (in_tdata),
    .win           (win),
    .s1            (s1),
    .s1_old_sample (s1_old_sample)
  );

  rrod_energy u_energy (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .s1            (s1),
    .s1_old_sample (s1_old_sample),
    .s3            (s3),
    .run           (run)
  );

  rrod_decide u_decide (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .s3         (s3),
    .run        (run),
    .out_tready (out_tready),
    .stall      (stall),
    .out_tvalid (out_tvalid),
    .out_found  (found),
    .out_start  (start),
    .out_energy (energy)
  );

  assign out_tdata = OUT_DATA_W'({energy, start});
  assign out_tuser = found;

endmodule

`default_nettype wire

### rtl/rrod_hist.sv
// sample history ram with write pointer, fill count and sample index
// depends on rrod_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rrod_hist import rrod_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic                    in_restart,
  input  wire logic signed [SMP_W-1:0] in_sample,
  input  wire logic [CWIN_W-1:0]       win,
  output s1_t                          s1,
  output logic        [SMP_W-1:0]      s1_old_sample
);

  logic [SMP_W-1:0]   mem [MAX_WINDOW];
  logic [HIST_AW-1:0] hist_pos_r, hist_pos_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [HIST_AW-1:0] old_pos;
  logic [SMP_W-1:0]   old_sample_r;
  s1_t                s1_r, s1_nxt;
  logic               accept;

  assign accept  = in_valid && en;
  // window start position; a full-depth window reads the slot about to be overwritten
  assign old_pos = hist_pos_r - win[HIST_AW-1:0];

  always_comb begin
    hist_pos_nxt = hist_pos_r;
    fill_nxt     = fill_r;
    idx_nxt      = idx_r;
    if (accept) begin
      if (in_restart) begin
        hist_pos_nxt = '0;
        fill_nxt     = '0;
        idx_nxt      = '0;
      end else begin
        hist_pos_nxt = hist_pos_r + HIST_AW'(1);
        fill_nxt     = (fill_r == FILL_W'(MAX_WINDOW)) ? fill_r : fill_r + FILL_W'(1);
        idx_nxt      = idx_r + IDX_W'(1);
      end
    end
    s1_nxt.valid     = accept;
    s1_nxt.restart   = in_restart;
    // slots not written since restart count as silence
    s1_nxt.old_valid = (fill_r >= FILL_W'(win));
    s1_nxt.sample    = in_sample;
    s1_nxt.idx       = idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_pos_r <= '0;
      fill_r     <= '0;
      idx_r      <= '0;
      s1_r.valid <= 1'b0;
    end else begin
      hist_pos_r <= hist_pos_nxt;
      fill_r     <= fill_nxt;
      idx_r      <= idx_nxt;
      if (en) s1_r <= s1_nxt;
    end
  end

  // read-before-write on the same slot
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!in_restart) mem[hist_pos_r] <= in_sample;
      old_sample_r <= mem[old_pos];
    end
  end

  assign s1            = s1_r;
  assign s1_old_sample = old_sample_r;

  `RROD_ASSERT(a_fill_bound, fill_r <= FILL_W'(MAX_WINDOW), "fill count beyond history depth")

endmodule

`default_nettype wire

### rtl/rrod_energy.sv
// squaring stage and running sum-of-squares accumulator
// depends on rrod_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rrod_energy import rrod_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire s1_t              s1,
  input  wire logic [SMP_W-1:0] s1_old_sample,
  output s3_t                   s3,
  output logic [RUN_W-1:0]      run
);

  logic signed [2*SMP_W-1:0] sq_full, old_sq_full;
  s2_t                       s2_r, s2_nxt;
  s3_t                       s3_r, s3_nxt;
  logic [RUN_W-1:0]          run_r, run_nxt;
  logic [RUN_W-1:0]          sum, old_ext;

  assign sq_full     = s1.sample * s1.sample;
  assign old_sq_full = $signed(s1_old_sample) * $signed(s1_old_sample);

  always_comb begin
    s2_nxt.valid   = s1.valid;
    s2_nxt.restart = s1.restart;
    s2_nxt.sq      = sq_full[SQ_W-1:0];
    s2_nxt.old_sq  = s1.old_valid ? old_sq_full[SQ_W-1:0] : '0;
    s2_nxt.idx     = s1.idx;
  end

  assign sum     = run_r + RUN_W'(s2_r.sq);
  assign old_ext = RUN_W'(s2_r.old_sq);

  always_comb begin
    run_nxt = run_r;
    if (s2_r.valid) begin
      if (s2_r.restart) run_nxt = '0;
      // saturate at zero when the window length changed under the sum
      else run_nxt = (sum >= old_ext) ? sum - old_ext : '0;
    end
    s3_nxt.valid   = s2_r.valid;
    s3_nxt.restart = s2_r.restart;
    s3_nxt.idx     = s2_r.idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
      run_r      <= '0;
    end else if (en) begin
      s2_r  <= s2_nxt;
      s3_r  <= s3_nxt;
      run_r <= run_nxt;
    end
  end

  assign s3  = s3_r;
  assign run = run_r;

  `RROD_ASSERT_NEXT(a_run_hold, !en, $stable(run_r), "running sum moved during a stall")

endmodule

`default_nettype wire

### rtl/rrod_decide.sv
// window evaluation, search state and result register
// depends on rrod_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rrod_decide import rrod_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire s3_t              s3,
  input  wire logic [RUN_W-1:0] run,
  input  wire logic             out_tready,
  output logic                  stall,
  output logic                  out_tvalid,
  output logic                  out_found,
  output logic [IDX_W-1:0]      out_start,
  output logic [ENG_W-1:0]      out_energy
);

  logic               done_r, done_nxt;
  logic [1:0]         seen_r, seen_nxt;
  logic [IDX_W-1:0]   nws_r, nws_nxt;
  logic [ENG_W-1:0]   prev_r, prev_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [IDX_W-1:0]   out_start_r, out_start_nxt;
  logic [ENG_W-1:0]   out_energy_r, out_energy_nxt;

  logic [CWIN_W-1:0]  w, hop;
  logic [IDX_W-1:0]   end_idx;
  logic [IDX_W:0]     hop_sum;
  logic [IDX_W-1:0]   nws_step;
  logic [ENG_W-1:0]   e_sat;
  logic [PROD_W-1:0]  prod, e_scaled;
  logic               rise, over_thr, at_end, go, emit, fire;

  assign w        = clamp_window(cfg.window_size);
  assign hop      = clamp_hop(cfg.hop_length);
  assign end_idx  = nws_r + IDX_W'(w) - IDX_W'(1);
  assign at_end   = (s3.idx == end_idx);
  assign hop_sum  = {1'b0, nws_r} + (IDX_W+1)'(hop);
  assign nws_step = hop_sum[IDX_W] ? '1 : hop_sum[IDX_W-1:0];
  assign e_sat    = (|run[RUN_W-1:ENG_W]) ? '1 : run[ENG_W-1:0];
  assign prod     = PROD_W'(cfg.ratio_q8) * PROD_W'(prev_r);
  assign e_scaled = PROD_W'({run, {Q_FRAC{1'b0}}});
  // silent previous window counts as ratio one
  assign rise     = (prev_r == '0) ? (cfg.ratio_q8 < RATIO_ONE) : (e_scaled > prod);
  assign over_thr = (run > RUN_W'(cfg.energy_threshold));

  // a sample of an open search waits while the last result is still unclaimed
  assign stall = out_valid_r && s3.valid && !s3.restart && !done_r;
  assign go    = s3.valid && !stall;

  always_comb begin
    done_nxt       = done_r;
    seen_nxt       = seen_r;
    nws_nxt        = nws_r;
    prev_nxt       = prev_r;
    emit           = 1'b0;
    fire           = 1'b0;
    out_found_nxt  = out_found_r;
    out_start_nxt  = out_start_r;
    out_energy_nxt = out_energy_r;
    if (go) begin
      if (s3.restart) begin
        done_nxt = 1'b0;
        seen_nxt = '0;
        nws_nxt  = cfg.start_index;
        prev_nxt = '0;
      end else if (!done_r) begin
        if (nws_r >= cfg.search_limit) begin
          emit = 1'b1;
        end else begin
          if (at_end) begin
            if (seen_r < 2'd2) seen_nxt = seen_r + 2'd1;
            else fire = rise && over_thr;
            prev_nxt = e_sat;
            if (!fire) nws_nxt = nws_step;
          end
          if (fire || (nws_nxt >= cfg.search_limit)) emit = 1'b1;
        end
        if (emit) begin
          done_nxt       = 1'b1;
          out_found_nxt  = fire;
          out_start_nxt  = fire ? nws_r : '0;
          out_energy_nxt = fire ? e_sat : '0;
        end
      end
    end
    if (emit) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= 1'b0;
      seen_r      <= '0;
      nws_r       <= START_RESET;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      seen_r      <= seen_nxt;
      nws_r       <= nws_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r  <= out_found_nxt;
    out_start_r  <= out_start_nxt;
    out_energy_r <= out_energy_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_found  = out_found_r;
  assign out_start  = out_start_r;
  assign out_energy = out_energy_r;

  `RROD_ASSERT(a_slot_free, !(emit && out_valid_r), "result produced over a pending result")
  `RROD_ASSERT_NEXT(a_done_after_emit, emit, done_r && out_valid_r, "search left open after result")
  `RROD_ASSERT(a_miss_zero, !(out_valid_r && !out_found_r) || (out_start_r == '0 && out_energy_r == '0), "not-found result carries data")

endmodule

`default_nettype wire

### test/tb_rms_ratio_onset_detector_unit.sv
// self-checking testbench for rms_ratio_onset_detector_unit
// drives audio samples and restarts, predicts onset results, compares each result transfer
// depends on rrod_pkg and the rtl of the onset detector
`timescale 1ns / 1ps

module tb_rms_ratio_onset_detector_unit;
  import rrod_pkg::*;

  localparam logic ACT_SAMPLE  = 1'b0;
  localparam logic ACT_RESTART = 1'b1;
  localparam longint ENG_MAX   = (longint'(1) << ENG_W) - 1;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 200;
  localparam int PHASE_RESULTS = 3;

  typedef struct packed {
    logic             action;
    logic [SMP_W-1:0] sample;
  } audio_item_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] start;
    logic [ENG_W-1:0] energy;
  } onset_res_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [SMP_W-1:0]      in_tdata   = '0;   // [15:0] sample
  logic [0:0]            in_tuser   = '0;   // [0] action
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [23:0] window_start, [65:24] window_energy
  logic [0:0]            out_tuser;         // [0] found
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_AW-1:0]     cfg_index  = '0;
  logic [CFG_W-1:0]      cfg_wdata  = '0;

  // stimulus and expected results
  audio_item_t audio_q[$];
  onset_res_t  pending_onsets[$];
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic hold_kick    = 1'b0;
  int hold_left;
  int mismatches   = 0;
  int live_items   = 0;
  int results_seen = 0;

  // predictor copy of the detector
  cfg_t                    shadow;
  logic [IDX_W-1:0]        smp_count;
  logic signed [SMP_W-1:0] smp_hist [MAX_WINDOW];
  logic [HIST_AW-1:0]      hist_pos;
  longint                  sum_sq;
  longint                  last_energy;
  int                      windows_logged;
  logic [IDX_W-1:0]        win_start;
  bit                      search_closed;

  rms_ratio_onset_detector_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic clear_search();
    smp_count = '0;
    foreach (smp_hist[i]) smp_hist[i] = '0;
    hist_pos       = '0;
    sum_sq         = 0;
    last_energy    = 0;
    windows_logged = 0;
    win_start      = shadow.start_index;
    search_closed  = 1'b0;
  endtask

  task automatic predict_onset(input logic act, input logic [SMP_W-1:0] raw);
    logic [CWIN_W-1:0]  w;
    logic [CWIN_W-1:0]  hop;
    logic [HIST_AW-1:0] old_pos;
    logic [IDX_W-1:0]   end_idx;
    logic [IDX_W:0]     nxt;
    longint             x;
    longint             y;
    longint             e;
    bit                 fire;
    bit                 rise;
    onset_res_t         r;
    fire = 1'b0;
    r    = '0;
    if (act == ACT_RESTART) begin
      live_items++;
      clear_search();
      return;
    end
    if (search_closed) return;
    live_items++;
    if (win_start >= shadow.search_limit) begin
      search_closed = 1'b1;
      pending_onsets.insert(pending_onsets.size(), r);
      return;
    end
    w = shadow.window_size;
    if (w == '0) w = CWIN_W'(1);
    else if (w > CWIN_W'(MAX_WINDOW)) w = CWIN_W'(MAX_WINDOW);
    hop = (shadow.hop_length == '0) ? CWIN_W'(1) : shadow.hop_length;
    // drop the oldest square of the window, never below zero
    old_pos = hist_pos - HIST_AW'(w);
    x = longint'($signed(raw));
    y = longint'(smp_hist[old_pos]);
    smp_hist[hist_pos] = $signed(raw);
    hist_pos++;
    sum_sq = sum_sq + x * x;
    sum_sq = (sum_sq >= y * y) ? sum_sq - y * y : 0;
    end_idx = win_start + IDX_W'(w) - IDX_W'(1);
    if (smp_count == end_idx) begin
      e = sum_sq;
      if (windows_logged < 2) begin
        windows_logged++;
      end else begin
        rise = (last_energy == 0) ? (shadow.ratio_q8 < RATIO_ONE)
                                  : ((e << 8) > longint'(shadow.ratio_q8) * last_energy);
        fire = rise && (e > longint'(shadow.energy_threshold));
      end
      last_energy = (e > ENG_MAX) ? ENG_MAX : e;
      if (fire) begin
        r.found  = 1'b1;
        r.start  = win_start;
        r.energy = ENG_W'(last_energy);
        search_closed = 1'b1;
        pending_onsets.insert(pending_onsets.size(), r);
      end else begin
        nxt = {1'b0, win_start} + (IDX_W + 1)'(hop);
        win_start = nxt[IDX_W] ? '1 : nxt[IDX_W-1:0];
      end
    end
    smp_count++;
    if (!fire && win_start >= shadow.search_limit) begin
      search_closed = 1'b1;
      pending_onsets.insert(pending_onsets.size(), r);
    end
  endtask

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  task automatic push_item(input logic act, input logic [SMP_W-1:0] smp);
    audio_item_t it;
    it.action = act;
    it.sample = smp;
    audio_q.insert(audio_q.size(), it);
  endtask

  // registers are only written while nothing is in flight
  task automatic configure(input cfg_t c);
    logic [CFG_W-1:0] val;
    for (int i = 0; i <= int'(CFG_ENERGY_THRESHOLD); i++) begin
      case (cfg_reg_t'(i))
        CFG_START_INDEX:      val = CFG_W'(c.start_index);
        CFG_SEARCH_LIMIT:     val = CFG_W'(c.search_limit);
        CFG_WINDOW_SIZE:      val = CFG_W'(c.window_size);
        CFG_HOP_LENGTH:       val = CFG_W'(c.hop_length);
        CFG_RATIO_Q8:         val = CFG_W'(c.ratio_q8);
        default:              val = CFG_W'(c.energy_threshold);
      endcase
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_wdata <= val;
      @(posedge clk);
      cfg_wr_en <= 1'b0;
    end
    shadow = c;
    @(negedge clk);
  endtask

  // all items sent and every expected result seen, then let the pipeline empty
  task automatic wait_quiet();
    do @(negedge clk);
    while (audio_q.size() != 0 || in_tvalid || pending_onsets.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic run_search();
    cfg_t   c;
    longint lim;
    int     quiet_amp;
    int     burst_at;
    int     n;
    c = shadow;
    if ($urandom_range(2) == 0) begin
      case ($urandom_range(9))
        0:       c.start_index = '0;
        9:       c.start_index = IDX_W'(24'hFFFFFF - $urandom_range(0, 40));
        default: c.start_index = IDX_W'($urandom_range(1, 24));
      endcase
      lim = longint'(c.start_index) + $urandom_range(0, 60);
      case ($urandom_range(7))
        0:       c.search_limit = '0;
        1:       c.search_limit = '1;
        default: c.search_limit = (lim > 64'hFFFFFF) ? '1 : IDX_W'(lim);
      endcase
      c.window_size = ($urandom_range(9) == 0) ? '0 : CWIN_W'($urandom_range(1, 16));
      c.hop_length  = ($urandom_range(7) == 0) ? '0 : CWIN_W'($urandom_range(1, 12));
      case ($urandom_range(5))
        0:       c.ratio_q8 = '0;
        1:       c.ratio_q8 = RATIO_W'(255);
        2:       c.ratio_q8 = RATIO_ONE;
        3:       c.ratio_q8 = '1;
        default: c.ratio_q8 = RATIO_W'($urandom_range(257, 2048));
      endcase
      case ($urandom_range(4))
        0:       c.energy_threshold = '0;
        1:       c.energy_threshold = '1;
        default: c.energy_threshold = ENG_W'($urandom_range(0, 3000000));
      endcase
      configure(c);
    end
    case ($urandom_range(3))
      0:       quiet_amp = 0;
      1:       quiet_amp = 3;
      2:       quiet_amp = 100;
      default: quiet_amp = 2000;
    endcase
    burst_at = $urandom_range(0, 60);
    push_item(ACT_RESTART, '0);
    for (int ch = 0; ch < 6; ch++) begin
      for (int k = 0; k < 12; k++) begin
        n = ch * 12 + k;
        if ($urandom_range(39) == 0) push_item(ACT_RESTART, SMP_W'($urandom));
        else if (n >= burst_at) push_item(ACT_SAMPLE, SMP_W'($urandom));
        else push_item(ACT_SAMPLE, SMP_W'($urandom_range(0, 2 * quiet_amp) - quiet_amp));
      end
      wait_quiet();
      if (search_closed) break;
      // reshape the window while the search is still open
      if ($urandom_range(3) == 0) begin
        c = shadow;
        c.window_size = CWIN_W'($urandom_range(0, 20));
        c.hop_length  = CWIN_W'($urandom_range(0, 12));
        configure(c);
      end
    end
  endtask

  // sender: one item per transfer, gaps drawn per free slot
  always @(posedge clk) begin
    audio_item_t item;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_onset(in_tuser[0], in_tdata);
      if (!in_tvalid || in_tready) begin
        if (audio_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item = audio_q[0];
          audio_q.delete(0);
          in_tvalid <= 1'b1;
          in_tdata  <= item.sample;
          in_tuser  <= item.action;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else begin
      if (hold_kick) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      out_tready <= !hold_kick && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    onset_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_onsets.size() == 0) begin
        flag_error($sformatf("unexpected result: found=%0d start=%0h energy=%0h",
                             out_tuser[0], out_tdata[IDX_W-1:0],
                             out_tdata[IDX_W+ENG_W-1:IDX_W]));
      end else begin
        want = pending_onsets[0];
        pending_onsets.delete(0);
        if (out_tuser[0] !== want.found || out_tdata[IDX_W-1:0] !== want.start ||
            out_tdata[IDX_W+ENG_W-1:IDX_W] !== want.energy)
          flag_error($sformatf({"result mismatch: expected found=%0d start=%0h energy=%0h,",
                                " got found=%0d start=%0h energy=%0h"},
                               want.found, want.start, want.energy, out_tuser[0],
                               out_tdata[IDX_W-1:0], out_tdata[IDX_W+ENG_W-1:IDX_W]));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    cfg_t c;
    int   base_live;
    int   base_res;
    shadow = '{start_index: START_RESET, search_limit: LIMIT_RESET, window_size: WIN_RESET,
               hop_length: HOP_RESET, ratio_q8: RATIO_RESET, energy_threshold: THR_RESET};
    clear_search();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // quiet start then full-scale swings, ratio test with a nonzero previous window
    c = '{start_index: 24'd1, search_limit: 24'd40, window_size: 13'd4, hop_length: 13'd2,
          ratio_q8: 16'd512, energy_threshold: '0};
    configure(c);
    push_item(ACT_RESTART, '0);
    push_item(ACT_SAMPLE, 16'd1);
    push_item(ACT_SAMPLE, 16'd1);
    push_item(ACT_SAMPLE, 16'hFFFF);
    push_item(ACT_SAMPLE, 16'd1);
    push_item(ACT_SAMPLE, 16'd0);
    push_item(ACT_SAMPLE, 16'd1);
    push_item(ACT_SAMPLE, 16'h7FFF);
    push_item(ACT_SAMPLE, 16'h8000);
    push_item(ACT_SAMPLE, 16'h7FFF);
    push_item(ACT_SAMPLE, 16'h8000);
    push_item(ACT_SAMPLE, 16'h5555);
    push_item(ACT_SAMPLE, 16'hAAAA);
    push_item(ACT_RESTART, 16'hFFFF);
    wait_quiet();

    // zero window and hop act as one, zero previous energy counts as ratio one
    c = '{start_index: '0, search_limit: '1, window_size: '0, hop_length: '0,
          ratio_q8: '0, energy_threshold: '0};
    configure(c);
    push_item(ACT_RESTART, '0);
    push_item(ACT_SAMPLE, 16'd0);
    push_item(ACT_SAMPLE, 16'd0);
    push_item(ACT_SAMPLE, 16'd0);
    push_item(ACT_SAMPLE, 16'd5);
    push_item(ACT_SAMPLE, 16'd7);
    wait_quiet();

    // limit already reached before the first sample
    c.search_limit = '0;
    configure(c);
    push_item(ACT_RESTART, '0);
    push_item(ACT_SAMPLE, 16'd3);
    push_item(ACT_SAMPLE, 16'd4);
    wait_quiet();

    // window end wraps past the top index, next start saturates
    c = '{start_index: 24'hFFFFFC, search_limit: '1, window_size: 13'd8, hop_length: 13'd8,
          ratio_q8: RATIO_RESET, energy_threshold: '0};
    configure(c);
    push_item(ACT_RESTART, '0);
    repeat (4) push_item(ACT_SAMPLE, SMP_W'($urandom));
    wait_quiet();

    // oversize window acting as the largest one, its end wraps to a low index
    c = '{start_index: 24'hFFF002, search_limit: '1, window_size: '1, hop_length: 13'd1,
          ratio_q8: RATIO_ONE, energy_threshold: '0};
    configure(c);
    push_item(ACT_RESTART, '0);
    repeat (6) push_item(ACT_SAMPLE, 16'h8000);
    wait_quiet();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1:       begin send_idle_pct <= 48; recv_stall_pct <= 0;  end
        2:       begin send_idle_pct <= 0;  recv_stall_pct <= 48; end
        default: begin send_idle_pct <= 36; recv_stall_pct <= 36; end
      endcase
      @(negedge clk);
      base_live = live_items;
      base_res  = results_seen;
      while (live_items - base_live < PHASE_ITEMS || results_seen - base_res < PHASE_RESULTS)
        run_search();
    end

    // a result waits behind a held receiver until the input stalls, then again with random stalls
    c = '{start_index: '0, search_limit: '1, window_size: 13'd1, hop_length: 13'd1,
          ratio_q8: '0, energy_threshold: '0};
    configure(c);
    for (int pass = 0; pass < 2; pass++) begin
      send_idle_pct  <= 0;
      recv_stall_pct <= (pass == 0) ? 0 : 36;
      @(posedge clk);
      hold_kick <= (pass == 0);
      @(posedge clk);
      hold_kick <= 1'b0;
      @(negedge clk);
      repeat (20) begin
        push_item(ACT_RESTART, '0);
        repeat (5) push_item(ACT_SAMPLE, SMP_W'($urandom_range(1, 65535)));
      end
      wait_quiet();
    end

    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
